// ===== rtl/esbg_pkg.sv =====
`timescale 1ns / 1ps

package esbg_pkg;

  localparam int unsigned MAX_STEP_MS_DEF = 100;
  localparam int unsigned FULL_LEVEL_DEF  = 1000000;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int IN_W      = 80;
  localparam int OUT_W     = 48;
  localparam int THR_W     = 11;
  localparam int BONUS_W   = 16;
  localparam int LEVEL_W   = 20;
  localparam int PROD_W    = 27;
  localparam int QIN_W     = 20;
  localparam int RECIP_W   = 21;
  localparam int RECIP_SHIFT = 30;

  localparam int unsigned PERMILLE = 1000;
  localparam logic [PROD_W-1:0]  CLAMP_LIMIT = PROD_W'(1001000);
  localparam logic [RECIP_W-1:0] RECIP_1000  = RECIP_W'(1073742);
  localparam logic signed [THR_W-1:0] THR_MAX = 11'sd1000;
  localparam logic [THR_W-1:0] BRAKE_THR_RST = 11'h418;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPLOY_RATE    = 3'd0,
    REG_OVERTAKE_RATE  = 3'd1,
    REG_BOOST_BONUS    = 3'd2,
    REG_OVERTAKE_BONUS = 3'd3,
    REG_BRAKE_THR      = 3'd4,
    REG_COAST_BAND     = 3'd5,
    REG_BRAKE_RATE     = 3'd6,
    REG_COAST_RATE     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]             deploy_rate;
    logic [15:0]             overtake_rate;
    logic [15:0]             boost_bonus;
    logic [15:0]             overtake_bonus;
    logic signed [THR_W-1:0] brake_threshold;
    logic [9:0]              coast_band;
    logic [15:0]             brake_harvest_rate;
    logic [15:0]             coast_harvest_rate;
  } esbg_cfg_t;

  typedef struct packed {
    logic                    pass;
    logic signed [THR_W-1:0] shaped;
    logic [PROD_W-1:0]       prod;
  } esbg_scale_t;

endpackage

// ===== rtl/esbg_energy.sv =====
`timescale 1ns / 1ps

module esbg_energy #(
  parameter int unsigned MAX_STEP_MS = esbg_pkg::MAX_STEP_MS_DEF,
  parameter int unsigned FULL_LEVEL  = esbg_pkg::FULL_LEVEL_DEF,
  parameter int EW = $clog2(FULL_LEVEL + 1)
) (
  input  esbg_pkg::esbg_cfg_t                cfg,
  input  logic                               seeded,
  input  logic [31:0]                        last_time,
  input  logic [EW-1:0]                      store,
  input  logic [31:0]                        now_ms,
  input  logic                               system_enabled,
  input  logic signed [esbg_pkg::THR_W-1:0]  commanded_throttle,
  input  logic [15:0]                        wheel_speed,
  input  logic                               boost_button,
  input  logic                               overtake_button,
  input  logic signed [esbg_pkg::THR_W-1:0]  shaped_throttle,
  output logic [EW-1:0]                      store_next,
  output logic                               deploy,
  output logic [esbg_pkg::BONUS_W-1:0]       bonus,
  output esbg_pkg::esbg_scale_t              scale
);
  import esbg_pkg::*;

  localparam int DTW = $clog2(MAX_STEP_MS + 1);
  localparam int MW  = 16 + DTW;
  localparam int SW  = ((EW > MW) ? EW : MW) + 1;

  logic [31:0]         elapsed;
  logic [DTW-1:0]      dt;
  logic                active;
  logic                braking;
  logic                coasting;
  logic signed [11:0]  cmd_ext;
  logic signed [11:0]  band;
  logic [15:0]         rate;
  logic [15:0]         hrate;
  logic [MW-1:0]       amount;
  logic [SW-1:0]       store_ext;
  logic [SW-1:0]       amount_ext;
  logic [SW-1:0]       sum;
  logic                harvest;

  assign elapsed = now_ms - last_time;
  assign dt = (elapsed > 32'(MAX_STEP_MS)) ? DTW'(MAX_STEP_MS) : elapsed[DTW-1:0];
  assign active = seeded && system_enabled;

  assign deploy = active && (boost_button || overtake_button) &&
                  (commanded_throttle > 11'sd0) && (store != '0);

  assign cmd_ext  = {commanded_throttle[THR_W-1], commanded_throttle};
  assign band     = $signed({2'b00, cfg.coast_band});
  assign braking  = commanded_throttle <= cfg.brake_threshold;
  assign coasting = (cmd_ext >= -band) && (cmd_ext <= band);

  always_comb begin
    if (braking) begin
      hrate = cfg.brake_harvest_rate;
    end else if (coasting) begin
      hrate = cfg.coast_harvest_rate;
    end else begin
      hrate = '0;
    end
  end

  // one shared rate times elapsed time for drain and harvest
  assign rate = deploy ? (overtake_button ? cfg.overtake_rate : cfg.deploy_rate) : hrate;
  assign amount = MW'(rate) * MW'(dt);

  assign harvest    = active && !deploy && (wheel_speed != '0);
  assign store_ext  = SW'(store);
  assign amount_ext = SW'(amount);
  assign sum        = store_ext + amount_ext;

  always_comb begin
    if (deploy) begin
      store_next = (amount_ext >= store_ext) ? '0 : EW'(store_ext - amount_ext);
    end else if (harvest) begin
      store_next = (sum > SW'(FULL_LEVEL)) ? EW'(FULL_LEVEL) : sum[EW-1:0];
    end else begin
      store_next = store;
    end
  end

  assign bonus = deploy ? (overtake_button ? cfg.overtake_bonus : cfg.boost_bonus) : '0;

  assign scale.pass   = (bonus == '0) || !(shaped_throttle > 11'sd0);
  assign scale.shaped = shaped_throttle;
  assign scale.prod   = PROD_W'(shaped_throttle[THR_W-2:0]) *
                        (PROD_W'(bonus) + PROD_W'(PERMILLE));

endmodule

// ===== rtl/esbg_scale.sv =====
`timescale 1ns / 1ps

module esbg_scale (
  input  esbg_pkg::esbg_scale_t              scale,
  output logic signed [esbg_pkg::THR_W-1:0]  throttle
);
  import esbg_pkg::*;

  localparam int QW = QIN_W + RECIP_W;

  logic [QW-1:0] qfull;
  logic [THR_W-1:0] quot;

  // divide by 1000 through a reciprocal, exact below the clamp point
  assign qfull = QW'(scale.prod[QIN_W-1:0]) * QW'(RECIP_1000);
  assign quot  = qfull[RECIP_SHIFT +: THR_W];

  always_comb begin
    if (scale.pass) begin
      throttle = scale.shaped;
    end else if (scale.prod >= CLAMP_LIMIT) begin
      throttle = THR_MAX;
    end else begin
      throttle = $signed(quot);
    end
  end

endmodule

// ===== rtl/energy_store_boost_governor_core.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake               payload
// s_axis    in         s_tvalid / s_tready     s_tdata: one control tick
// m_axis    out        m_tvalid / m_tready     m_tdata: scaled throttle, bonus, level
// cfg       in         cfg_wen                 cfg_index, cfg_wdata
//
// three register stages (input, product, output); one item per cycle sustained
// while the output is ready; the result is registered in the output stage
// the energy store and tick time update as an item leaves the input stage
// rst clears store, time seed, valids and config, but brake threshold goes to -1000
// a stalled output holds full stages; input stalls only when all stages are full
module energy_store_boost_governor_core #(
  parameter int unsigned MAX_STEP_MS = esbg_pkg::MAX_STEP_MS_DEF,
  parameter int unsigned FULL_LEVEL  = esbg_pkg::FULL_LEVEL_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [esbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esbg_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // now_ms[31:0], system_enabled[32], commanded_throttle[43:33],
  // wheel_speed[59:44], boost_button[60], overtake_button[61],
  // shaped_throttle[72:62], zero[79:73]
  input  logic [esbg_pkg::IN_W-1:0]       s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // boosted_throttle[10:0], active_bonus[26:11], energy_level[46:27], zero[47]
  output logic [esbg_pkg::OUT_W-1:0]      m_tdata
);
  import esbg_pkg::*;

  localparam int EW = $clog2(FULL_LEVEL + 1);
  localparam int XW = (EW > LEVEL_W) ? EW : LEVEL_W;

  esbg_cfg_t cfg;

  logic        seeded;
  logic [31:0] last_time;
  logic [EW-1:0] store;

  logic             a_valid;
  logic [IN_W-1:0]  a_data;
  logic             a_adv;
  logic             a_fire;

  logic                 b_valid;
  esbg_scale_t          b_scale;
  logic [BONUS_W-1:0]   b_bonus;
  logic [LEVEL_W-1:0]   b_level;
  logic                 b_adv;

  logic                    c_valid;
  logic signed [THR_W-1:0] c_throttle;
  logic [BONUS_W-1:0]      c_bonus;
  logic [LEVEL_W-1:0]      c_level;

  logic [EW-1:0]        store_next;
  logic                 deploy;
  logic [BONUS_W-1:0]   bonus;
  esbg_scale_t          scale;
  logic signed [THR_W-1:0] throttle;
  logic [XW-1:0]        level_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deploy_rate        <= '0;
      cfg.overtake_rate      <= '0;
      cfg.boost_bonus        <= '0;
      cfg.overtake_bonus     <= '0;
      cfg.brake_threshold    <= $signed(BRAKE_THR_RST);
      cfg.coast_band         <= '0;
      cfg.brake_harvest_rate <= '0;
      cfg.coast_harvest_rate <= '0;
    end else if (cfg_wen) begin
      case (reg_idx_t'(cfg_index))
        REG_DEPLOY_RATE:    cfg.deploy_rate        <= cfg_wdata;
        REG_OVERTAKE_RATE:  cfg.overtake_rate      <= cfg_wdata;
        REG_BOOST_BONUS:    cfg.boost_bonus        <= cfg_wdata;
        REG_OVERTAKE_BONUS: cfg.overtake_bonus     <= cfg_wdata;
        REG_BRAKE_THR:      cfg.brake_threshold    <= $signed(cfg_wdata[THR_W-1:0]);
        REG_COAST_BAND:     cfg.coast_band         <= cfg_wdata[9:0];
        REG_BRAKE_RATE:     cfg.brake_harvest_rate <= cfg_wdata;
        REG_COAST_RATE:     cfg.coast_harvest_rate <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign b_adv    = !c_valid || m_tready;
  assign a_adv    = !b_valid || b_adv;
  assign a_fire   = a_valid && a_adv;
  assign s_tready = !a_valid || a_adv;

  esbg_energy #(
    .MAX_STEP_MS(MAX_STEP_MS),
    .FULL_LEVEL (FULL_LEVEL),
    .EW         (EW)
  ) u_energy (
    .cfg               (cfg),
    .seeded            (seeded),
    .last_time         (last_time),
    .store             (store),
    .now_ms            (a_data[31:0]),
    .system_enabled    (a_data[32]),
    .commanded_throttle($signed(a_data[43:33])),
    .wheel_speed       (a_data[59:44]),
    .boost_button      (a_data[60]),
    .overtake_button   (a_data[61]),
    .shaped_throttle   ($signed(a_data[72:62])),
    .store_next        (store_next),
    .deploy            (deploy),
    .bonus             (bonus),
    .scale             (scale)
  );

  assign level_ext = XW'(store_next);

  esbg_scale u_scale (
    .scale   (b_scale),
    .throttle(throttle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      seeded    <= 1'b0;
      last_time <= '0;
      store     <= '0;
    end else begin
      if (s_tready) begin
        a_valid <= s_tvalid;
      end
      if (a_adv) begin
        b_valid <= a_valid;
      end
      if (b_adv) begin
        c_valid <= b_valid;
      end
      if (a_fire) begin
        seeded    <= 1'b1;
        last_time <= a_data[31:0];
        store     <= store_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      a_data <= s_tdata;
    end
    if (a_fire) begin
      b_scale <= scale;
      b_bonus <= bonus;
      b_level <= level_ext[LEVEL_W-1:0];
    end
    if (b_adv && b_valid) begin
      c_throttle <= throttle;
      c_bonus    <= b_bonus;
      c_level    <= b_level;
    end
  end

  assign m_tvalid = c_valid;
  assign m_tdata  = {1'b0, c_level, c_bonus, c_throttle};

  a_store_full: assert property (@(posedge clk) disable iff (rst)
    store <= EW'(FULL_LEVEL))
    else $error("energy store above full level");

  a_deploy_drains: assert property (@(posedge clk) disable iff (rst)
    a_fire && deploy |=> store <= $past(store))
    else $error("energy store grew during deployment");

  a_bonus_needs_deploy: assert property (@(posedge clk) disable iff (rst)
    a_fire && !deploy |-> bonus == '0)
    else $error("bonus granted without deployment");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !a_valid |-> s_tready)
    else $error("input stalled with empty input stage");

endmodule
